// ===== src/integer_to_ascii_formatter_core_defines.svh =====
// Assertion helpers for the integer-to-ASCII formatter.
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define ITA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked check that also holds through reset.
`define ITA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== src/ita_pkg.sv =====
package ita_pkg;

  // Pointer width; the other kinds use the low 32 bits.
  localparam int VALUE_BITS = 64;
  localparam int NIBBLES    = VALUE_BITS / 4;
  // Digit position: holds 0..15 for hex and 0..10 for decimal powers.
  localparam int POS_W      = 4;
  localparam int CNT_W      = 32;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6C;

  localparam logic [2:0] NIL_LAST = 3'd4;

  typedef enum logic [2:0] {
    KIND_SDEC = 3'd0,
    KIND_UDEC = 3'd1,
    KIND_HEXL = 3'd2,
    KIND_HEXU = 3'd3,
    KIND_PTR  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    JOB_DEC,
    JOB_HEX,
    JOB_NIL
  } job_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PRE0,
    BK_PRE1,
    BK_NIL,
    BK_DIGIT
  } back_e;

  // One classified request as it sits in the queue.
  typedef struct packed {
    job_e                  mode;
    logic                  neg;
    logic                  prefix;
    logic                  upper;
    logic [POS_W-1:0]      top;
    logic [VALUE_BITS-1:0] mag;
  } job_t;

  // Powers of ten up to 10^10.
  function automatic logic [33:0] pow10(input logic [POS_W-1:0] k);
    logic [33:0] p;
    case (k)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      4'd10:   p = 34'd10000000000;
      default: p = 34'd0;
    endcase
    return p;
  endfunction

  // Characters of the null pointer text.
  function automatic logic [7:0] nil_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = CH_LPAR;
      3'd1:    c = CH_N;
      3'd2:    c = CH_I;
      3'd3:    c = CH_L;
      3'd4:    c = CH_RPAR;
      default: c = CH_RPAR;
    endcase
    return c;
  endfunction

endpackage

// ===== src/ita_if.sv =====
// Request channel: one beat per number to format.
interface ita_req_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    req_type;
  logic [63:0]                   value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

// Character channel: one beat per ASCII character.
interface ita_char_if;
  logic                          valid;
  logic                          ready;
  logic [7:0]                    char_byte;
  logic                          last_of_run;
  logic [31:0]                   chars_total;

  modport source (output valid, output char_byte, output last_of_run,
                  output chars_total, input ready);
  modport sink   (input valid, input char_byte, input last_of_run,
                  input chars_total, output ready);
endinterface

// ===== src/ita_front.sv =====
// Accepts requests, drops unknown kinds and reduces each one to a job.
module ita_front (
  ita_req_if.sink          req_i,
  input  logic             full_i,
  output logic             push_o,
  output ita_pkg::job_t    job_o
);

  logic [31:0]                    w;
  logic [31:0]                    m32;
  logic [ita_pkg::VALUE_BITS-1:0] ptr;
  logic                           known;
  ita_pkg::job_t                  job;

  assign w   = req_i.value[31:0];
  assign ptr = req_i.value[ita_pkg::VALUE_BITS-1:0];

  // Classify by kind
  always_comb begin
    known      = 1'b1;
    m32        = w;
    job.mode   = ita_pkg::JOB_DEC;
    job.neg    = 1'b0;
    job.prefix = 1'b0;
    job.upper  = 1'b0;
    job.top    = '0;
    job.mag    = '0;
    case (ita_pkg::kind_e'(req_i.req_type))
      ita_pkg::KIND_SDEC: begin
        job.neg = w[31];
        // two's complement magnitude, exact for the most negative value
        m32     = w[31] ? (~w + 32'd1) : w;
        job.mag = ita_pkg::VALUE_BITS'(m32);
      end
      ita_pkg::KIND_UDEC: begin
        job.mag = ita_pkg::VALUE_BITS'(w);
      end
      ita_pkg::KIND_HEXL: begin
        job.mode = ita_pkg::JOB_HEX;
        job.mag  = ita_pkg::VALUE_BITS'(w);
      end
      ita_pkg::KIND_HEXU: begin
        job.mode  = ita_pkg::JOB_HEX;
        job.upper = 1'b1;
        job.mag   = ita_pkg::VALUE_BITS'(w);
      end
      ita_pkg::KIND_PTR: begin
        job.mag = ptr;
        if (ptr == '0) begin
          job.mode = ita_pkg::JOB_NIL;
        end else begin
          job.mode   = ita_pkg::JOB_HEX;
          job.prefix = 1'b1;
        end
      end
      default: begin
        known = 1'b0;
      end
    endcase

    // Leading digit position
    if (job.mode == ita_pkg::JOB_DEC) begin
      for (int i = 1; i < 10; i++) begin
        if ({2'b00, m32} >= ita_pkg::pow10(ita_pkg::POS_W'(i))) begin
          job.top = ita_pkg::POS_W'(i);
        end
      end
    end else if (job.mode == ita_pkg::JOB_HEX) begin
      for (int i = 0; i < ita_pkg::NIBBLES; i++) begin
        if (job.mag[i*4 +: 4] != 4'd0) begin
          job.top = ita_pkg::POS_W'(i);
        end
      end
    end
  end

  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i && known;
  assign job_o       = job;

endmodule

// ===== src/ita_fifo.sv =====
`include "integer_to_ascii_formatter_core_defines.svh"

// Short job queue between front and back.
module ita_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ita_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ita_pkg::job_t data_o
);

  ita_pkg::job_t                      mem_q [ita_pkg::FIFO_DEPTH];
  logic [ita_pkg::FIFO_PTR_W-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [ita_pkg::FIFO_CNT_W-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == ita_pkg::FIFO_CNT_W'(ita_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // Pointer and fill level update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == ita_pkg::FIFO_PTR_W'(ita_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == ita_pkg::FIFO_PTR_W'(ita_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `ITA_ASSERT_ALWAYS(a_fifo_level, cnt_q <= ita_pkg::FIFO_CNT_W'(ita_pkg::FIFO_DEPTH), "queue level above depth")
  `ITA_ASSERT(a_fifo_pop_empty, pop_i |-> !empty_o, "pop from empty queue")

endmodule

// ===== src/ita_back.sv =====
`include "integer_to_ascii_formatter_core_defines.svh"

// Character sequencer: one character per cycle, unless the output is stalled.
module ita_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  ita_pkg::job_t   job_i,
  output logic            pop_o,
  ita_char_if.source      chr_o
);

  ita_pkg::back_e                 state_q, state_d;
  logic [ita_pkg::VALUE_BITS-1:0] mag_q, mag_d;
  logic [ita_pkg::POS_W-1:0]      pos_q, pos_d;
  logic                           upper_q, upper_d;
  logic                           dec_q, dec_d;
  logic                           prefix_q, prefix_d;

  logic                           ovalid_q;
  logic [7:0]                     obyte_q;
  logic                           olast_q;
  logic [ita_pkg::CNT_W-1:0]      cnt_q, cnt_inc;

  logic                           adv, emit, last;
  logic [7:0]                     ch;
  logic [33:0]                    pw, sub;
  logic [3:0]                     digit, nib;
  logic [7:0]                     hex_ch;

  assign adv = !ovalid_q || chr_o.ready;

  // Decimal digit: largest multiple of the current power not above the rest
  always_comb begin
    pw    = ita_pkg::pow10(pos_q);
    digit = 4'd0;
    sub   = '0;
    for (int d = 1; d < 10; d++) begin
      if ({2'b00, mag_q[31:0]} >= pw * 34'(d)) begin
        digit = 4'(d);
        sub   = pw * 34'(d);
      end
    end
  end

  // Hex digit at the current nibble
  always_comb begin
    nib = mag_q[pos_q*4 +: 4];
    if (nib < 4'd10) begin
      hex_ch = ita_pkg::CH_ZERO + {4'd0, nib};
    end else begin
      hex_ch = (upper_q ? ita_pkg::CH_UA : ita_pkg::CH_LA) + {4'd0, nib} - 8'd10;
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    mag_d    = mag_q;
    pos_d    = pos_q;
    upper_d  = upper_q;
    dec_d    = dec_q;
    prefix_d = prefix_q;
    pop_o    = 1'b0;
    emit     = 1'b0;
    last     = 1'b0;
    ch       = ita_pkg::CH_ZERO;
    case (state_q)
      ita_pkg::BK_IDLE: begin
        if (!empty_i) begin
          pop_o    = 1'b1;
          mag_d    = job_i.mag;
          pos_d    = job_i.top;
          upper_d  = job_i.upper;
          dec_d    = (job_i.mode == ita_pkg::JOB_DEC);
          prefix_d = job_i.prefix;
          if (job_i.mode == ita_pkg::JOB_NIL) begin
            pos_d   = '0;
            state_d = ita_pkg::BK_NIL;
          end else if (job_i.neg || job_i.prefix) begin
            state_d = ita_pkg::BK_PRE0;
          end else begin
            state_d = ita_pkg::BK_DIGIT;
          end
        end
      end
      ita_pkg::BK_PRE0: begin
        ch = prefix_q ? ita_pkg::CH_ZERO : ita_pkg::CH_MINUS;
        if (adv) begin
          emit    = 1'b1;
          state_d = prefix_q ? ita_pkg::BK_PRE1 : ita_pkg::BK_DIGIT;
        end
      end
      ita_pkg::BK_PRE1: begin
        ch = ita_pkg::CH_X;
        if (adv) begin
          emit    = 1'b1;
          state_d = ita_pkg::BK_DIGIT;
        end
      end
      ita_pkg::BK_NIL: begin
        ch   = ita_pkg::nil_char(pos_q[2:0]);
        last = (pos_q[2:0] == ita_pkg::NIL_LAST);
        if (adv) begin
          emit  = 1'b1;
          pos_d = pos_q + 1'b1;
          if (last) begin
            state_d = ita_pkg::BK_IDLE;
          end
        end
      end
      ita_pkg::BK_DIGIT: begin
        ch   = dec_q ? (ita_pkg::CH_ZERO + {4'd0, digit}) : hex_ch;
        last = (pos_q == '0);
        if (adv) begin
          emit = 1'b1;
          if (dec_q) begin
            mag_d = mag_q - ita_pkg::VALUE_BITS'(sub);
          end
          if (last) begin
            state_d = ita_pkg::BK_IDLE;
          end else begin
            pos_d = pos_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = ita_pkg::BK_IDLE;
      end
    endcase
  end

  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ita_pkg::BK_IDLE;
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (adv) begin
        ovalid_q <= emit;
      end
      if (emit) begin
        cnt_q <= cnt_inc;
      end
    end
  end

  // Job and output payload
  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    pos_q    <= pos_d;
    upper_q  <= upper_d;
    dec_q    <= dec_d;
    prefix_q <= prefix_d;
    if (emit) begin
      obyte_q <= ch;
      olast_q <= last;
    end
  end

  assign chr_o.valid       = ovalid_q;
  assign chr_o.char_byte   = obyte_q;
  assign chr_o.last_of_run = olast_q;
  assign chr_o.chars_total = cnt_q;

  `ITA_ASSERT(a_dec_rest_bound, (state_q == ita_pkg::BK_DIGIT && dec_q) |-> ({2'b00, mag_q[31:0]} < ita_pkg::pow10(ita_pkg::POS_W'(pos_q + 1'b1))), "decimal remainder out of range")
  `ITA_ASSERT(a_cnt_monotonic, 1'b1 |=> (cnt_q >= $past(cnt_q)), "character count went down")
  `ITA_ASSERT(a_last_is_digit, (chr_o.valid && chr_o.last_of_run) |-> ((chr_o.char_byte >= 8'h30 && chr_o.char_byte <= 8'h39) || (chr_o.char_byte >= 8'h41 && chr_o.char_byte <= 8'h46) || (chr_o.char_byte >= 8'h61 && chr_o.char_byte <= 8'h66) || chr_o.char_byte == 8'h29), "final character is not a digit")

endmodule

// ===== src/integer_to_ascii_formatter_core.sv =====
// Path: accepted requests go into a 2-entry job queue, which lets the front
//   take requests while the back-end sequencer works through an item of n
//   characters (1 to 18), one character per cycle into the output register
//   while the sink takes beats, and pops the next job only once it is idle.
// Reset: rst_ni is asynchronous, active low; it empties the queue, idles the
//   sequencer, drops the output beat and clears the character count.
module integer_to_ascii_formatter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  ita_req_if.sink     req_i,
  ita_char_if.source  chr_o
);

  logic          push, pop, full, empty;
  ita_pkg::job_t job_in, job_out;

  ita_front u_front (
    .req_i  (req_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job_in)
  );

  ita_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (job_out)
  );

  ita_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .job_i   (job_out),
    .pop_o   (pop),
    .chr_o   (chr_o)
  );

endmodule
